FILE: src/wmts_pkg.sv
// ----------------------------------------------------------------------------
// wmts_pkg
// Shared types and constants for the wav mono to stereo streamer: input modes,
// status codes, header byte offsets and the command passed from front to back.
// ----------------------------------------------------------------------------
package wmts_pkg;

    localparam int HEADER_BYTES = 44;

    // input modes (s_axis_tuser)
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_END    = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    // stream phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_HEADER  = 4'd1;
    localparam logic [3:0] ST_BAD_FORMAT  = 4'd2;
    localparam logic [3:0] ST_TOO_LARGE   = 4'd3;
    localparam logic [3:0] ST_TOO_LONG    = 4'd4;
    localparam logic [3:0] ST_OVERFLOW    = 4'd5;
    localparam logic [3:0] ST_CANCELLED   = 4'd6;
    localparam logic [3:0] ST_TRUNCATED   = 4'd7;
    localparam logic [3:0] ST_NOT_STARTED = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAME_BYTES = 2'd1;
    localparam logic [1:0] CFG_MAX_DURATION_MS = 2'd2;

    // header byte offsets at which a little-endian field is complete
    localparam logic [5:0] HDR_RIFF_TAG    = 6'd3;
    localparam logic [5:0] HDR_RIFF_SIZE   = 6'd7;
    localparam logic [5:0] HDR_WAVE_TAG    = 6'd11;
    localparam logic [5:0] HDR_FMT_TAG     = 6'd15;
    localparam logic [5:0] HDR_FMT_SIZE    = 6'd19;
    localparam logic [5:0] HDR_AUDIO_FMT   = 6'd21;
    localparam logic [5:0] HDR_CHANNELS    = 6'd23;
    localparam logic [5:0] HDR_SAMPLE_RATE = 6'd27;
    localparam logic [5:0] HDR_BYTE_RATE   = 6'd31;
    localparam logic [5:0] HDR_BLOCK_ALIGN = 6'd33;
    localparam logic [5:0] HDR_BITS        = 6'd35;
    localparam logic [5:0] HDR_DATA_TAG    = 6'd39;
    localparam logic [5:0] HDR_LAST        = 6'(HEADER_BYTES - 1);

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] FMT_MONO       = 16'd1;
    localparam logic [31:0] FMT_RATE       = 32'd16000;
    localparam logic [31:0] FMT_BYTE_RATE  = 32'd32000;
    localparam logic [15:0] FMT_ALIGN      = 16'd2;
    localparam logic [15:0] FMT_BITS       = 16'd16;

    // reset values of the configuration registers
    localparam logic [31:0] RST_FRAME_LENGTH    = 32'd0;
    localparam logic [31:0] RST_MAX_FRAME_BYTES = 32'd1048576;
    localparam logic [26:0] RST_MAX_DURATION_MS = 27'd30000;

    // work item from the front to the back: a status report or a sample pair
    typedef struct packed {
        logic               is_pair;
        logic signed [15:0] sample;
        logic [3:0]         status;
    } t_cmd;

endpackage

FILE: src/wmts_front.sv
// ----------------------------------------------------------------------------
// wmts_front
// Accepts one stream item per cycle while the command queue is not full, parses
// the wav header, counts pcm bytes, keeps the sticky status and pushes report or sample-pair commands.
// ----------------------------------------------------------------------------
module wmts_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_byte,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output wmts_pkg::t_cmd       o_cmd
);
    import wmts_pkg::*;

    // configuration, with derived values worked out at write time
    logic [31:0] r_frame_len;
    logic [31:0] r_fl_m8;
    logic [31:0] r_fl_m44;
    logic        r_fl_small;
    logic [31:0] r_max_frame;
    logic [32:0] r_dur_lim;
    logic [27:0] w_dur_p1;

    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_hidx, n_hidx;
    logic [31:0] r_shift, n_shift;
    logic        r_hbad, n_hbad;
    logic        r_fbad, n_fbad;
    logic [31:0] r_expected, n_expected;
    logic [31:0] r_received, n_received;
    logic [7:0]  r_held, n_held;
    logic        r_held_v, n_held_v;
    logic [3:0]  r_sticky, n_sticky;

    logic        w_accept;
    logic [31:0] w_acc;
    logic [15:0] w_hi;
    logic [3:0]  w_verdict;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_acc    = {i_byte, r_shift[31:8]};
    assign w_hi     = w_acc[31:16];
    assign w_dur_p1 = {1'b0, i_cfg_data[26:0]} + 28'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= RST_FRAME_LENGTH;
            r_fl_m8     <= RST_FRAME_LENGTH - 32'd8;
            r_fl_m44    <= RST_FRAME_LENGTH - 32'(HEADER_BYTES);
            r_fl_small  <= (RST_FRAME_LENGTH < 32'(HEADER_BYTES));
            r_max_frame <= RST_MAX_FRAME_BYTES;
            r_dur_lim   <= {({1'b0, RST_MAX_DURATION_MS} + 28'd1), 5'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_LENGTH: begin
                    r_frame_len <= i_cfg_data;
                    r_fl_m8     <= i_cfg_data - 32'd8;
                    r_fl_m44    <= i_cfg_data - 32'(HEADER_BYTES);
                    r_fl_small  <= (i_cfg_data < 32'(HEADER_BYTES));
                end
                CFG_MAX_FRAME_BYTES: r_max_frame <= i_cfg_data;
                CFG_MAX_DURATION_MS: r_dur_lim   <= {w_dur_p1, 5'd0};
                default: ;
            endcase
        end
    end

    // verdict on the last header byte, highest priority first
    always_comb begin
        if (r_frame_len > r_max_frame) begin
            w_verdict = ST_TOO_LARGE;
        end else if (r_hbad || r_fl_small) begin
            w_verdict = ST_BAD_HEADER;
        end else if (r_fbad) begin
            w_verdict = ST_BAD_FORMAT;
        end else if (w_acc[0] || (w_acc != r_fl_m44)) begin
            w_verdict = ST_BAD_HEADER;
        end else if ({1'b0, w_acc} >= r_dur_lim) begin
            w_verdict = ST_TOO_LONG;
        end else begin
            w_verdict = ST_OK;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_shift    = r_shift;
        n_hbad     = r_hbad;
        n_fbad     = r_fbad;
        n_expected = r_expected;
        n_received = r_received;
        n_held     = r_held;
        n_held_v   = r_held_v;
        n_sticky   = r_sticky;
        o_push     = 1'b0;
        o_cmd      = '{is_pair: 1'b0, sample: 16'sd0, status: ST_OK};

        if (w_accept) begin
            unique case (i_mode)
                MODE_START: begin
                    n_phase    = PH_HEADER;
                    n_hidx     = '0;
                    n_shift    = '0;
                    n_hbad     = 1'b0;
                    n_fbad     = 1'b0;
                    n_expected = '0;
                    n_received = '0;
                    n_held     = '0;
                    n_held_v   = 1'b0;
                    n_sticky   = ST_OK;
                end
                MODE_DATA: begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_NOT_STARTED;
                        end
                        PH_HEADER: begin
                            n_shift = w_acc;
                            unique case (r_hidx)
                                HDR_RIFF_TAG:    n_hbad = r_hbad || (w_acc != TAG_RIFF);
                                HDR_RIFF_SIZE:   n_hbad = r_hbad || (w_acc != r_fl_m8);
                                HDR_WAVE_TAG:    n_hbad = r_hbad || (w_acc != TAG_WAVE);
                                HDR_FMT_TAG:     n_hbad = r_hbad || (w_acc != TAG_FMT);
                                HDR_FMT_SIZE:    n_hbad = r_hbad || (w_acc != FMT_CHUNK_SIZE);
                                HDR_AUDIO_FMT:   n_fbad = r_fbad || (w_hi != FMT_PCM);
                                HDR_CHANNELS:    n_fbad = r_fbad || (w_hi != FMT_MONO);
                                HDR_SAMPLE_RATE: n_fbad = r_fbad || (w_acc != FMT_RATE);
                                HDR_BYTE_RATE:   n_fbad = r_fbad || (w_acc != FMT_BYTE_RATE);
                                HDR_BLOCK_ALIGN: n_fbad = r_fbad || (w_hi != FMT_ALIGN);
                                HDR_BITS:        n_fbad = r_fbad || (w_hi != FMT_BITS);
                                HDR_DATA_TAG:    n_hbad = r_hbad || (w_acc != TAG_DATA);
                                default: ;
                            endcase
                            if (r_hidx != HDR_LAST) begin
                                n_hidx = r_hidx + 6'd1;
                            end else begin
                                o_push       = 1'b1;
                                o_cmd.status = w_verdict;
                                n_sticky     = w_verdict;
                                if (w_verdict == ST_OK) begin
                                    n_expected = w_acc;
                                    n_received = '0;
                                    n_phase    = PH_DATA;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                        PH_DATA: begin
                            if (r_received == r_expected) begin
                                // byte past the announced data size
                                n_sticky     = ST_OVERFLOW;
                                n_phase      = PH_DONE;
                                o_push       = 1'b1;
                                o_cmd.status = ST_OVERFLOW;
                            end else begin
                                n_received = r_received + 32'd1;
                                if (!r_held_v) begin
                                    n_held   = i_byte;
                                    n_held_v = 1'b1;
                                end else begin
                                    n_held_v      = 1'b0;
                                    o_push        = 1'b1;
                                    o_cmd.is_pair = 1'b1;
                                    o_cmd.sample  = {i_byte, r_held};
                                end
                            end
                        end
                        default: begin
                            o_push       = 1'b1;
                            o_cmd.status = (r_sticky != ST_OK) ? r_sticky : ST_NOT_STARTED;
                        end
                    endcase
                end
                MODE_END: begin
                    o_push = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        o_cmd.status = ST_NOT_STARTED;
                    end else begin
                        if ((r_phase == PH_HEADER) ||
                            ((r_phase == PH_DATA) &&
                             ((r_received != r_expected) || r_held_v))) begin
                            n_sticky = ST_TRUNCATED;
                        end
                        n_phase      = PH_DONE;
                        o_cmd.status = n_sticky;
                    end
                end
                default: begin
                    o_push = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        o_cmd.status = ST_NOT_STARTED;
                    end else begin
                        if (r_phase != PH_DONE) begin
                            n_sticky = ST_CANCELLED;
                            n_phase  = PH_DONE;
                        end
                        o_cmd.status = n_sticky;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hidx     <= '0;
            r_shift    <= '0;
            r_hbad     <= 1'b0;
            r_fbad     <= 1'b0;
            r_expected <= '0;
            r_received <= '0;
            r_held     <= '0;
            r_held_v   <= 1'b0;
            r_sticky   <= ST_OK;
        end else begin
            r_phase    <= n_phase;
            r_hidx     <= n_hidx;
            r_shift    <= n_shift;
            r_hbad     <= n_hbad;
            r_fbad     <= n_fbad;
            r_expected <= n_expected;
            r_received <= n_received;
            r_held     <= n_held;
            r_held_v   <= n_held_v;
            r_sticky   <= n_sticky;
        end
    end

endmodule

FILE: src/wmts_queue.sv
// ----------------------------------------------------------------------------
// wmts_queue
// Small register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module wmts_queue #(
    parameter int DEPTH = 4   // 2 to 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wmts_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output wmts_pkg::t_cmd o_cmd
);
    import wmts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: src/wmts_back.sv
// ----------------------------------------------------------------------------
// wmts_back
// Turns queued commands into output transfers: a report gives one, a sample
// pair gives left then right. Holds the output register.
// ----------------------------------------------------------------------------
module wmts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  wmts_pkg::t_cmd     i_q_cmd,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic [3:0]         o_status,
    output logic               o_last
);
    import wmts_pkg::*;

    logic r_valid;
    logic r_right;   // left of the current pair already issued
    logic w_load;

    assign w_load  = !r_valid || i_ready;
    assign o_q_pop = w_load && i_q_valid && (!i_q_cmd.is_pair || r_right);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_right <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            if (i_q_valid && i_q_cmd.is_pair) begin
                r_right <= !r_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            o_kind    <= i_q_cmd.is_pair;
            o_sample  <= i_q_cmd.is_pair ? i_q_cmd.sample : 16'sd0;
            o_channel <= i_q_cmd.is_pair && r_right;
            o_status  <= i_q_cmd.is_pair ? ST_OK : i_q_cmd.status;
            o_last    <= !i_q_cmd.is_pair || r_right;
        end
    end

endmodule

FILE: src/wav_mono_to_stereo_streamer.sv
// ----------------------------------------------------------------------------
// wav_mono_to_stereo_streamer
// Parses a 44-byte pcm16 wav header from a byte stream, reports its status,
// then emits each 16-bit mono sample as a left and a right sample.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                    tuser   tlast
//  s_axis    in   data_byte[7:0]                        mode    -
//  m_axis    out  sample[15:0] channel status[3:0] 000  kind    last
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// one input transfer per cycle while the queue has room; the front decides
// each item in that cycle and a command passes through the queue register
// into the output register. a sample pair gives two output transfers, so
// the m_axis side sets the sustained rate: one byte per cycle for reports
// and pcm data while m_axis_tready stays high. synchronous active-low reset, no clearing pass.
// s_axis_tready drops only when the command queue is full.
// ----------------------------------------------------------------------------
module wav_mono_to_stereo_streamer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sample[15:0], channel[16], status[20:17], zero
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast
);
    import wmts_pkg::*;

    logic               w_push, w_full, w_q_valid, w_pop;
    t_cmd               w_cmd, w_q_cmd;
    logic signed [15:0] w_sample;
    logic               w_channel;
    logic [3:0]         w_status;

    wmts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_q_full   (w_full),
        .o_ready    (s_axis_tready),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    wmts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    wmts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_sample  (w_sample),
        .o_channel (w_channel),
        .o_status  (w_status),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_status, w_channel, w_sample};

    // a left sample is always followed at once by its right sample
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tdata[16])
        |=> (m_axis_tvalid && m_axis_tuser && m_axis_tdata[16]))
        else $error("right sample did not follow left sample");

    // the left sample never closes an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && !m_axis_tdata[16]) |-> !m_axis_tlast)
        else $error("left sample marked last");

    // nothing leaves right after reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
